// ===== hdl/dsg_pkg.sv =====
// Package for the digital segment generator: widths, constants and the
// request and point payload types. Depends on nothing; every other file
// imports it.
package dsg_pkg;

  // Width of every coordinate field on the ports.
  localparam int COORD_W = 5;
  // Default number of coordinate bits that take part in the computation.
  localparam int COORD_BITS_DEF = 5;
  // Width of the internal two's complement values: base coordinates,
  // interval values and the odd-shifted values, which reach -31..93.
  localparam int VAL_W = 8;
  // Offset added to odd interval values before ordering.
  localparam int ODD_OFFSET = 32;
  localparam logic [VAL_W-1:0] ODD_ADD = VAL_W'(ODD_OFFSET);

  typedef struct packed {
    logic [COORD_W-1:0] x_start;
    logic [COORD_W-1:0] y_start;
    logic [COORD_W-1:0] x_end;
    logic [COORD_W-1:0] y_end;
  } seg_req_t;

  typedef struct packed {
    logic [COORD_W-1:0] x_point;
    logic [COORD_W-1:0] y_point;
    logic               last_point;
  } seg_pt_t;

endpackage

// ===== hdl/digital_segment_2d_generator.sv =====
// Top level of the digital segment generator: request decode, rank scan
// sequencer and point output register. Uses dsg_pkg and dsg_order.
//
//   channel | valid     | stall     | payload          | direction
//   request | req_valid | req_stall | req (seg_req_t)  | into the block
//   point   | pt_valid  | pt_stall  | pt  (seg_pt_t)   | out of the block
//
// A segment has at most 63 points. Each step scans every value of the
// interval once through the single ordering comparator, one value a cycle.
// req_stall is high from acceptance until the last point has been taken.
// Reset (rst, synchronous) returns the sequencer to idle; no point is lost
// or repeated under any pattern of pt_stall.
module digital_segment_2d_generator
  import dsg_pkg::*;
#(
  parameter int COORD_BITS = COORD_BITS_DEF
) (
  input  logic     clk,
  input  logic     rst,
  input  logic     req_valid,
  output logic     req_stall,
  input  seg_req_t req,
  output logic     pt_valid,
  input  logic     pt_stall,
  output seg_pt_t  pt
);

  localparam int RANK_W = COORD_BITS + 1;
  localparam logic [COORD_W-1:0] CMASK = COORD_W'((1 << COORD_BITS) - 1);

  typedef enum logic [1:0] {
    IDLE,
    SCAN,
    EMIT
  } state_t;

  state_t state;

  logic [VAL_W-1:0]  s_val;
  logic [VAL_W-1:0]  e_val;
  logic [VAL_W-1:0]  i_val;
  logic [VAL_W-1:0]  j_val;
  logic [RANK_W-1:0] rank;
  logic [RANK_W-1:0] dx;
  logic              neg;
  logic              rev;
  logic [VAL_W-1:0]  cx;
  logic [VAL_W-1:0]  cy;
  logic              last;

  // Request decode.
  logic [VAL_W-1:0] x1, y1, x2, y2;
  logic [VAL_W-1:0] sx, sy, ex, ey;
  logic [VAL_W-1:0] s_in, e_in, dx_full;
  logic             neg_in, rev_in;

  always_comb begin
    x1 = VAL_W'(req.x_start & CMASK);
    y1 = VAL_W'(req.y_start & CMASK);
    x2 = VAL_W'(req.x_end & CMASK);
    y2 = VAL_W'(req.y_end & CMASK);
    neg_in = 1'b0;
    rev_in = 1'b0;
    // Every octant is brought to the case start <= end in both axes.
    priority if (x1 >= x2 && y1 >= y2) begin
      sx = x2;
      sy = y2;
      ex = x1;
      ey = y1;
      rev_in = 1'b1;
    end else if (x2 < x1 && y2 > y1) begin
      sx = -x1;
      sy = y1;
      ex = -x2;
      ey = y2;
      neg_in = 1'b1;
    end else if (x1 < x2 && y2 < y1) begin
      sx = -x2;
      sy = y2;
      ex = -x1;
      ey = y1;
      neg_in = 1'b1;
      rev_in = 1'b1;
    end else begin
      sx = x1;
      sy = y1;
      ex = x2;
      ey = y2;
    end
    s_in    = sx + sy;
    e_in    = ex + ey;
    dx_full = ex - sx;
  end

  // Shared comparator and the rank step around it.
  logic              prec;
  logic [RANK_W-1:0] rank_sum;
  logic              step_x;
  logic              scan_done;

  dsg_order u_order (
    .cand     (j_val),
    .ref_val  (i_val),
    .precedes (prec)
  );

  always_comb begin
    rank_sum  = rank + RANK_W'((j_val != i_val) && prec);
    step_x    = rank_sum < dx;
    scan_done = (j_val == e_val - VAL_W'(1));
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= IDLE;
    end else begin
      unique case (state)
        IDLE: begin
          if (req_valid) begin
            s_val <= s_in;
            e_val <= e_in;
            dx    <= dx_full[RANK_W-1:0];
            neg   <= neg_in;
            rev   <= rev_in;
            // A reversed segment is walked backwards from its far end.
            cx    <= rev_in ? ex : sx;
            cy    <= rev_in ? ey : sy;
            i_val <= rev_in ? (e_in - VAL_W'(1)) : s_in;
            last  <= (s_in == e_in);
            state <= EMIT;
          end
        end
        EMIT: begin
          if (!pt_stall) begin
            if (last) begin
              state <= IDLE;
            end else begin
              j_val <= s_val;
              rank  <= '0;
              state <= SCAN;
            end
          end
        end
        SCAN: begin
          if (scan_done) begin
            if (rev) begin
              cx    <= step_x ? (cx - VAL_W'(1)) : cx;
              cy    <= step_x ? cy : (cy - VAL_W'(1));
              last  <= (i_val == s_val);
              i_val <= i_val - VAL_W'(1);
            end else begin
              cx    <= step_x ? (cx + VAL_W'(1)) : cx;
              cy    <= step_x ? cy : (cy + VAL_W'(1));
              last  <= (i_val == e_val - VAL_W'(1));
              i_val <= i_val + VAL_W'(1);
            end
            state <= EMIT;
          end else begin
            rank  <= rank_sum;
            j_val <= j_val + VAL_W'(1);
          end
        end
        default: state <= IDLE;
      endcase
    end
  end

  logic [VAL_W-1:0] px;

  always_comb begin
    px            = neg ? -cx : cx;
    req_stall     = (state != IDLE);
    pt_valid      = (state == EMIT);
    pt.x_point    = px[COORD_W-1:0];
    pt.y_point    = cy[COORD_W-1:0];
    pt.last_point = last;
  end

endmodule

// ===== hdl/dsg_order.sv =====
// Shared ordering comparator of the segment generator: tells whether one
// interval value precedes another in the ranking order. Uses dsg_pkg.
module dsg_order
  import dsg_pkg::*;
(
  input  logic [VAL_W-1:0] cand,
  input  logic [VAL_W-1:0] ref_val,
  output logic             precedes
);

  logic [VAL_W-1:0] cand_sh;
  logic [VAL_W-1:0] ref_sh;
  logic [VAL_W-1:0] diff;
  logic [VAL_W-1:0] low_bit;

  // The first offset at which the 2-adic valuations part lands on the lowest
  // bit where the shifted values differ; the value holding a one there has
  // the smaller valuation and comes first. Equal values precede neither way.
  always_comb begin
    cand_sh  = cand + (cand[0] ? ODD_ADD : '0);
    ref_sh   = ref_val + (ref_val[0] ? ODD_ADD : '0);
    diff     = cand_sh ^ ref_sh;
    low_bit  = diff & (~diff + VAL_W'(1));
    precedes = |(cand_sh & low_bit);
  end

endmodule

// ===== hdl/dsg_checker.sv =====
// Port-level checker for the digital segment generator, bound to the top
// level below. Uses dsg_pkg for the payload types.
module dsg_checker
  import dsg_pkg::*;
(
  input logic     clk,
  input logic     rst,
  input logic     req_valid,
  input logic     req_stall,
  input logic     pt_valid,
  input logic     pt_stall,
  input seg_pt_t  pt
);

  // An accepted request shows its first point in the next cycle.
  a_first_point: assert property (@(posedge clk) disable iff (rst)
    req_valid && !req_stall |=> pt_valid)
    else $error("no point after an accepted request");

  // No new request is taken while a point is on offer.
  a_busy_emit: assert property (@(posedge clk) disable iff (rst)
    pt_valid |-> req_stall)
    else $error("request port open while a point is pending");

  // Taking the last point frees the request port at once.
  a_release: assert property (@(posedge clk) disable iff (rst)
    pt_valid && !pt_stall && pt.last_point |=> !req_stall && !pt_valid)
    else $error("block not idle after the last point");

  // A stalled point stays on offer unchanged.
  a_hold: assert property (@(posedge clk) disable iff (rst)
    pt_valid && pt_stall |=> pt_valid && $stable(pt))
    else $error("stalled point changed");

endmodule

bind digital_segment_2d_generator dsg_checker u_dsg_checker (.*);

// ===== sim/digital_segment_2d_generator_tb.sv =====
// Self-checking testbench for digital_segment_2d_generator: drives endpoint requests,
// predicts every segment point in a scoreboard class and checks each point as it leaves.
// Depends on dsg_pkg and the digital_segment_2d_generator RTL.
module digital_segment_2d_generator_tb import dsg_pkg::*; ();
  timeunit 1ns;
  timeprecision 1ps;

  class segment_checker;
    seg_pt_t points_due[$];
    int      mismatches;
    int      walk_x[$];
    int      walk_y[$];

    // The 2-adic valuation; zero counts as deeper than any real value.
    function int valuation(int v);
      int n;
      n = 0;
      if (v == 0) return 64;
      while (v[0] == 1'b0) begin
        v = v >> 1;
        n++;
      end
      return n;
    endfunction

    function int odd_lift(int v);
      return v[0] ? v + ODD_OFFSET : v;
    endfunction

    // True when value a strictly precedes value b in the step ranking.
    function bit ranks_ahead(int a, int b);
      int la, lb, va, vb, t;
      la = odd_lift(a);
      lb = odd_lift(b);
      if (la == lb) return 1'b0;
      for (t = 0; t < 1024; t++) begin
        va = valuation(la - t);
        vb = valuation(lb - t);
        if (va != vb) return va < vb;
      end
      return 1'b0;
    endfunction

    // Traces the segment with start <= end on both axes into walk_x and walk_y.
    function void walk_base(int sx, int sy, int ex, int ey);
      int lo, hi, dx, cx, cy, rank, i, j;
      lo = sx + sy;
      hi = ex + ey;
      dx = ex - sx;
      cx = sx;
      cy = sy;
      walk_x = {cx};
      walk_y = {cy};
      for (i = lo; i < hi; i++) begin
        rank = 0;
        for (j = lo; j < hi; j++)
          if (j != i && ranks_ahead(j, i)) rank++;
        if (rank < dx) cx++;
        else cy++;
        walk_x = {walk_x, cx};
        walk_y = {walk_y, cy};
      end
    endfunction

    function void note_request(seg_req_t r);
      int      x1, y1, x2, y2, n, k, src;
      bit      mirror, backward;
      seg_pt_t p;
      x1 = int'(r.x_start);
      y1 = int'(r.y_start);
      x2 = int'(r.x_end);
      y2 = int'(r.y_end);
      mirror = 1'b0;
      backward = 1'b0;
      // Other octants are folded onto the base case by swapping the endpoints
      // and/or negating x, and unfolded again when the points are queued.
      if (x1 == x2 && y1 == y2) begin
        walk_x = {x1};
        walk_y = {y1};
      end else if (x1 >= x2 && y1 >= y2) begin
        walk_base(x2, y2, x1, y1);
        backward = 1'b1;
      end else if (x2 < x1 && y2 > y1) begin
        walk_base(-x1, y1, -x2, y2);
        mirror = 1'b1;
      end else if (x1 < x2 && y2 < y1) begin
        walk_base(-x2, y2, -x1, y1);
        mirror = 1'b1;
        backward = 1'b1;
      end else begin
        walk_base(x1, y1, x2, y2);
      end
      n = walk_x.size();
      for (k = 0; k < n; k++) begin
        src = backward ? n - 1 - k : k;
        p.x_point = COORD_W'(mirror ? -walk_x[src] : walk_x[src]);
        p.y_point = COORD_W'(walk_y[src]);
        p.last_point = (k == n - 1);
        points_due = {points_due, p};
      end
    endfunction

    function void check_point(seg_pt_t got);
      seg_pt_t want;
      if (points_due.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("unexpected point x=%0d y=%0d last=%0d with nothing pending",
                   got.x_point, got.y_point, got.last_point);
        return;
      end
      want = points_due.pop_front();
      if (got.x_point !== want.x_point || got.y_point !== want.y_point ||
          got.last_point !== want.last_point) begin
        mismatches++;
        if (mismatches <= 10)
          $display("point mismatch: expected x=%0d y=%0d last=%0d, got x=%0d y=%0d last=%0d",
                   want.x_point, want.y_point, want.last_point,
                   got.x_point, got.y_point, got.last_point);
      end
    endfunction
  endclass

  logic     clk = 1'b0;
  logic     rst = 1'b1;
  logic     req_valid = 1'b0;
  logic     req_stall;
  seg_req_t req = '0;
  logic     pt_valid;
  logic     pt_stall = 1'b0;
  seg_pt_t  pt;

  segment_checker sb;
  bit             steady = 1'b0;

  digital_segment_2d_generator uut (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req_valid),
    .req_stall (req_stall),
    .req       (req),
    .pt_valid  (pt_valid),
    .pt_stall  (pt_stall),
    .pt        (pt)
  );

  initial begin
    forever #2 clk = ~clk;
  end

  initial begin
    #20_000_000;
    $display("FAIL digital_segment_2d_generator");
    $finish;
  end

  always @(negedge clk) begin
    pt_stall <= !steady && ($urandom_range(99) < 8);
  end

  always @(posedge clk) begin
    if (!rst && pt_valid && !pt_stall) sb.check_point(pt);
  end

  task automatic send_request(input int x1, input int y1, input int x2, input int y2);
    seg_req_t r;
    r.x_start = COORD_W'(x1);
    r.y_start = COORD_W'(y1);
    r.x_end = COORD_W'(x2);
    r.y_end = COORD_W'(y2);
    @(negedge clk);
    while (!steady && $urandom_range(99) < 8) begin
      req_valid <= 1'b0;
      @(negedge clk);
    end
    req_valid <= 1'b1;
    req <= r;
    @(posedge clk);
    while (req_stall) @(posedge clk);
    sb.note_request(r);
  endtask

  function automatic int near(int c);
    int v;
    v = c + int'($urandom_range(8)) - 4;
    return v < 0 ? 0 : (v > 31 ? 31 : v);
  endfunction

  initial begin
    int x1, y1, mode;
    sb = new();
    repeat (6) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // Single points, the four full diagonals and the axis-aligned extremes.
    send_request(0, 0, 0, 0);
    send_request(31, 31, 31, 31);
    send_request(5, 9, 5, 9);
    send_request(0, 0, 31, 31);
    send_request(31, 31, 0, 0);
    send_request(31, 0, 0, 31);
    send_request(0, 31, 31, 0);
    send_request(0, 0, 31, 0);
    send_request(31, 0, 0, 0);
    send_request(0, 0, 0, 31);
    send_request(0, 31, 0, 0);
    // Requests for each octant fold: direct, swapped, mirrored, mirrored and swapped.
    send_request(3, 4, 10, 6);
    send_request(10, 6, 3, 4);
    send_request(12, 2, 4, 9);
    send_request(4, 9, 12, 2);
    send_request(7, 7, 8, 8);
    send_request(8, 8, 7, 7);
    send_request(20, 5, 21, 4);
    send_request(21, 4, 20, 5);
    send_request(31, 31, 30, 31);
    send_request(0, 5, 1, 5);
    send_request(16, 16, 15, 17);
    send_request(15, 17, 16, 16);
    send_request(21, 10, 10, 21);
    send_request(10, 21, 21, 10);

    for (int i = 0; i < 115; i++) begin
      steady = (i >= 50 && i < 90);
      mode = $urandom_range(99);
      if (mode < 60) begin
        // Short segments keep most requests quick.
        x1 = $urandom_range(31);
        y1 = $urandom_range(31);
        send_request(x1, y1, near(x1), near(y1));
      end else if (mode < 92) begin
        send_request($urandom_range(31), $urandom_range(31),
                     $urandom_range(31), $urandom_range(31));
      end else begin
        send_request($urandom_range(1) * 31, $urandom_range(1) * 31,
                     $urandom_range(1) * 31, $urandom_range(1) * 31);
      end
    end
    steady = 1'b0;
    @(negedge clk);
    req_valid <= 1'b0;

    while (sb.points_due.size() != 0) @(posedge clk);
    repeat (100) @(posedge clk);
    if (sb.mismatches == 0 && sb.points_due.size() == 0) begin
      $display("PASS digital_segment_2d_generator");
    end else begin
      $display("FAIL digital_segment_2d_generator");
    end
    $finish;
  end
endmodule

// ===== sim.f =====
hdl/dsg_pkg.sv
hdl/dsg_order.sv
hdl/digital_segment_2d_generator.sv
hdl/dsg_checker.sv
sim/digital_segment_2d_generator_tb.sv
